>>> design/mfpc_pkg.sv
// Shared types and constants for the motor fader position controller.
`default_nettype none

package mfpc_pkg;

    // Fixed field widths
    localparam int GAIN_BITS      = 16;
    localparam int TOL_BITS       = 12;
    localparam int ATTEMPT_BITS   = 8;
    localparam int LEVEL_BITS     = 13;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Speed saturation magnitudes and level mapping
    localparam int SPEED_BITS     = 13;
    localparam int SPEED_POS_MAG  = 4095;
    localparam int SPEED_NEG_MAG  = 4096;
    localparam int LEVEL_BASE     = 2458;
    localparam int LEVEL_DIVISOR  = 5;
    localparam int DIV_NUM_BITS   = SPEED_BITS + 1;   // holds 2*|speed|
    localparam int DIV_REM_BITS   = 3;                // remainder 0..4

    // Move status codes
    localparam logic [STATUS_BITS-1:0] ST_IDLE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MOVING  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_REACHED = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FAILED  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_POSITION = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_POSITION = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ATTEMPTS = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

>>> design/mfpc_if.sv
// Valid/ready channel interfaces for control ticks and drive results.
`default_nettype none

interface mfpc_in_if #(
    parameter int POSITION_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic                     start_move;
    logic [POSITION_BITS-1:0] setpoint;
    logic [POSITION_BITS-1:0] measured_position;

    modport source (output valid, output start_move, output setpoint,
                    output measured_position, input ready);
    modport sink   (input valid, input start_move, input setpoint,
                    input measured_position, output ready);
endinterface

interface mfpc_out_if;
    import mfpc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [LEVEL_BITS-1:0]  forward_level;
    logic [LEVEL_BITS-1:0]  reverse_level;
    logic [STATUS_BITS-1:0] move_status;

    modport source (output valid, output forward_level, output reverse_level,
                    output move_status, input ready);
    modport sink   (input valid, input forward_level, input reverse_level,
                    input move_status, output ready);
endinterface

`default_nettype wire

>>> design/motor_fader_position_controller.sv
// Top level: proportional fader position controller with serial multiply and level divide.
//
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     start_move, setpoint, measured_position
//  o_out     out  valid/ready     forward_level, reverse_level, move_status
//  i_cfg_*   in   write enable    i_cfg_index, i_cfg_data (no read-back)
//
// A tick that ends idle, reached or failed goes from the transfer directly to S_DONE.
// A drive tick runs through the transfer, the bit-serial gain multiply, a handoff,
// the serial divide by five, the collection of the level and the load of the output;
// a zero speed skips the divide.
// Reset is synchronous and active low; it restores register defaults and clears the move.
// One result register sits on the output; a new tick is taken while it waits,
// and a finished result waits in its last state until that register is free.
`default_nettype none

module motor_fader_position_controller #(
    parameter int POSITION_BITS  = 12,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    mfpc_in_if.sink                                   i_in,
    mfpc_out_if.source                                o_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mfpc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [mfpc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import mfpc_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int PW = GAIN_BITS + P;
    localparam int CW = (P > TOL_BITS) ? P : TOL_BITS;

    // configuration
    logic [P-1:0]            r_max_position;
    logic [P-1:0]            r_min_position;
    logic [TOL_BITS-1:0]     r_tolerance;
    logic [GAIN_BITS-1:0]    r_gain;
    logic [ATTEMPT_BITS-1:0] r_max_attempts;

    // control state
    t_state                  r_state,  n_state;
    logic                    r_move_active, n_move_active;
    logic [ATTEMPT_BITS-1:0] r_attempt, n_attempt;
    logic                    r_neg, n_neg;
    logic [LEVEL_BITS-1:0]   r_res_fwd, n_res_fwd;
    logic [LEVEL_BITS-1:0]   r_res_rev, n_res_rev;
    logic [STATUS_BITS-1:0]  r_res_status, n_res_status;
    logic                    r_out_valid, n_out_valid;
    logic [LEVEL_BITS-1:0]   r_out_fwd;
    logic [LEVEL_BITS-1:0]   r_out_rev;
    logic [STATUS_BITS-1:0]  r_out_status;

    // datapath
    logic                    w_accept;
    logic                    w_active;
    logic [ATTEMPT_BITS-1:0] w_count;
    logic [P-1:0]            w_tgt;
    logic                    w_tgt_neg;
    logic [P-1:0]            w_mag;
    logic                    w_within;
    logic                    w_mul_start;
    logic                    w_mul_done;
    logic [PW-1:0]           w_prod;
    logic [PW-1:0]           w_shift;
    logic [PW-1:0]           w_cap;
    logic [SPEED_BITS-1:0]   w_speed;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [DIV_NUM_BITS-1:0] w_quot;
    logic [LEVEL_BITS-1:0]   w_level;
    logic                    w_load;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_position <= P'(4095);
            r_min_position <= P'(21);
            r_tolerance    <= TOL_BITS'(10);
            r_gain         <= GAIN_BITS'(1638);
            r_max_attempts <= ATTEMPT_BITS'(200);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_POSITION: r_max_position <= i_cfg_data[P-1:0];
                CFG_MIN_POSITION: r_min_position <= i_cfg_data[P-1:0];
                CFG_TOLERANCE:    r_tolerance    <= i_cfg_data[TOL_BITS-1:0];
                CFG_GAIN:         r_gain         <= i_cfg_data[GAIN_BITS-1:0];
                CFG_MAX_ATTEMPTS: r_max_attempts <= i_cfg_data[ATTEMPT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp, error magnitude and tolerance check on the incoming tick
    always_comb begin
        w_active = i_in.start_move || r_move_active;
        w_count  = i_in.start_move ? '0 : r_attempt;
        if (i_in.setpoint > r_max_position) begin
            w_tgt = r_max_position;
        end else if (i_in.setpoint < r_min_position) begin
            w_tgt = r_min_position;
        end else begin
            w_tgt = i_in.setpoint;
        end
        w_tgt_neg = (w_tgt < i_in.measured_position);
        w_mag     = w_tgt_neg ? (i_in.measured_position - w_tgt)
                              : (w_tgt - i_in.measured_position);
        w_within  = (CW'(w_mag) <= CW'(r_tolerance));
    end

    // truncate toward zero on the magnitude, then saturate by sign
    always_comb begin
        w_shift = w_prod >> GAIN_FRAC_BITS;
        w_cap   = r_neg ? PW'(SPEED_NEG_MAG) : PW'(SPEED_POS_MAG);
        w_speed = (w_shift > w_cap) ? w_cap[SPEED_BITS-1:0] : w_shift[SPEED_BITS-1:0];
        w_level = LEVEL_BITS'(LEVEL_BASE) + w_quot[LEVEL_BITS-1:0];
    end

    assign w_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state       = r_state;
        n_move_active = r_move_active;
        n_attempt     = r_attempt;
        n_neg         = r_neg;
        n_res_fwd     = r_res_fwd;
        n_res_rev     = r_res_rev;
        n_res_status  = r_res_status;
        w_mul_start   = 1'b0;
        w_div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_move_active = w_active;
                    n_attempt     = w_count;
                    n_res_fwd     = '0;
                    n_res_rev     = '0;
                    n_neg         = w_tgt_neg;
                    n_state       = S_DONE;
                    if (!w_active) begin
                        n_res_status = ST_IDLE;
                    end else if (w_count >= r_max_attempts) begin
                        n_move_active = 1'b0;
                        n_res_status  = ST_FAILED;
                    end else if (w_within) begin
                        n_move_active = 1'b0;
                        n_res_status  = ST_REACHED;
                    end else begin
                        n_attempt    = w_count + 1'b1;
                        n_res_status = ST_MOVING;
                        w_mul_start  = 1'b1;
                        n_state      = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    if (w_speed == '0) begin
                        n_state = S_DONE;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res_fwd = r_neg ? '0 : w_level;
                    n_res_rev = r_neg ? w_level : '0;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = w_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_res_fwd    <= n_res_fwd;
        r_res_rev    <= n_res_rev;
        r_res_status <= n_res_status;
        if (w_load) begin
            r_out_fwd    <= r_res_fwd;
            r_out_rev    <= r_res_rev;
            r_out_status <= r_res_status;
        end
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_move_active <= 1'b0;
            r_attempt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_move_active <= n_move_active;
            r_attempt     <= n_attempt;
            r_out_valid   <= n_out_valid;
        end
    end

    mfpc_serial_mul #(
        .MAG_BITS (P)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_gain  (r_gain),
        .i_mag   (w_mag),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    mfpc_div5 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_speed, 1'b0}),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.forward_level = r_out_fwd;
    assign o_out.reverse_level = r_out_rev;
    assign o_out.move_status   = r_out_status;

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside the multiply phase");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_drive_only_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_fwd != '0 || r_out_rev != '0))
            |-> (r_out_status == ST_MOVING && (r_out_fwd == '0 || r_out_rev == '0)))
        else $error("drive level without a moving status or on both sides");

    a_end_clears_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_res_status == ST_REACHED || r_res_status == ST_FAILED))
            |-> !r_move_active)
        else $error("move still active after reached or failed result");

endmodule

`default_nettype wire

>>> design/mfpc_serial_mul.sv
// Shift-add multiplier: one gain bit per cycle, narrow adder on the error magnitude.
`default_nettype none

module mfpc_serial_mul #(
    parameter int MAG_BITS = 12
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_start,
    input  wire logic [mfpc_pkg::GAIN_BITS-1:0]             i_gain,
    input  wire logic [MAG_BITS-1:0]                        i_mag,
    output logic                                            o_done,
    output logic [mfpc_pkg::GAIN_BITS+MAG_BITS-1:0]         o_prod
);
    import mfpc_pkg::*;

    localparam int PW = GAIN_BITS + MAG_BITS;
    localparam int CW = $clog2(GAIN_BITS);

    logic [PW-1:0]       r_acc,  n_acc;
    logic [MAG_BITS-1:0] r_mag,  n_mag;
    logic [CW-1:0]       r_cnt,  n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [MAG_BITS:0]   w_sum;

    // high part accumulates the multiplicand, low part holds the remaining gain bits
    always_comb begin
        w_sum  = {1'b0, r_acc[PW-1:GAIN_BITS]} + (r_acc[0] ? {1'b0, r_mag} : '0);
        n_acc  = r_acc;
        n_mag  = r_mag;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = {{MAG_BITS{1'b0}}, i_gain};
            n_mag  = i_mag;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = {w_sum, r_acc[GAIN_BITS-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(GAIN_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mag <= n_mag;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

>>> design/mfpc_div5.sv
// Restoring divider by a constant five, one quotient bit per cycle.
`default_nettype none

module mfpc_div5 (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [mfpc_pkg::DIV_NUM_BITS-1:0] i_num,
    output logic                                   o_done,
    output logic [mfpc_pkg::DIV_NUM_BITS-1:0]      o_quot
);
    import mfpc_pkg::*;

    localparam int CW = $clog2(DIV_NUM_BITS);

    logic [DIV_NUM_BITS-1:0] r_num,  n_num;
    logic [DIV_REM_BITS-1:0] r_rem,  n_rem;
    logic [CW-1:0]           r_cnt,  n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [DIV_REM_BITS:0]   w_trial;
    logic                    w_qbit;

    // dividend shifts out MSB first, quotient bits shift in at the LSB
    always_comb begin
        w_trial = {r_rem, r_num[DIV_NUM_BITS-1]};
        w_qbit  = (w_trial >= (DIV_REM_BITS+1)'(LEVEL_DIVISOR));
        n_num   = r_num;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[DIV_NUM_BITS-2:0], w_qbit};
            n_rem = w_qbit ? DIV_REM_BITS'(w_trial - (DIV_REM_BITS+1)'(LEVEL_DIVISOR))
                           : w_trial[DIV_REM_BITS-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_NUM_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire
